[src/npsrch_pkg.sv]
// Shared constants for the nearest point search block.
package npsrch_pkg;

    // Fixed port widths of the coordinate and index fields.
    localparam int COORD_W = 15;
    localparam int IDX_W   = 8;

    // Defaults for the top-level parameters.
    localparam int MAX_POINTS_DEF = 255;
    localparam int COORD_BITS_DEF = 15;

endpackage

[src/npsrch_sqrt.sv]
// Iterative rounded integer square root, one result bit per cycle.
module npsrch_sqrt #(
    parameter int ROOT_BITS = npsrch_pkg::COORD_BITS_DEF + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [2*ROOT_BITS-1:0] i_radicand,
    output logic                   o_done,
    output logic [ROOT_BITS-1:0]   o_root
);

    localparam int SW = 2 * ROOT_BITS;
    localparam int RW = ROOT_BITS + 2;
    localparam int CW = $clog2(ROOT_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND
    } t_sqrt_state;

    t_sqrt_state          r_state;
    logic [SW-1:0]        r_rad;
    logic [RW-1:0]        r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [CW-1:0]        r_step;
    logic                 r_done;
    logic [ROOT_BITS-1:0] r_result;

    logic [RW-1:0]        n_rem_sh;
    logic [RW-1:0]        n_trial;
    logic                 n_fits;

    // Bring down the next two radicand bits and test the trial divisor.
    assign n_rem_sh = {r_rem[RW-3:0], r_rad[SW-1:SW-2]};
    assign n_trial  = {r_root, 2'b01};
    assign n_fits   = (n_rem_sh >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_rad   <= i_radicand;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= CW'(ROOT_BITS - 1);
                        r_state <= ST_ITER;
                    end
                end
                ST_ITER: begin
                    r_rad <= {r_rad[SW-3:0], 2'b00};
                    if (n_fits) begin
                        r_rem  <= n_rem_sh - n_trial;
                        r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
                    end else begin
                        r_rem  <= n_rem_sh;
                        r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
                    end
                    if (r_step == '0) begin
                        r_state <= ST_ROUND;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                ST_ROUND: begin
                    // Remainder above the root means the root lies past r + 0.5.
                    if (r_rem > {2'b00, r_root}) begin
                        r_result <= r_root + 1'b1;
                    end else begin
                        r_result <= r_root;
                    end
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_result;

endmodule

[src/nearest_point_search.sv]
// Top level of the nearest point search: sequencer, shared squarer and running best.
//
// Streaming nearest-neighbor search over 2-D points, one point per input transfer.
// A transfer with i_first high takes the origin from i_origin_x/i_origin_y and opens
// a new set; a transfer with i_last high closes the set and produces one result
// transfer carrying the position (from 0) of the first valid point with the smallest
// rounded distance, or 0 when no point was valid. A point with either coordinate equal
// to -1 takes a position but never wins; positions at MAX_POINTS and beyond are ignored.
// Distance is sqrt(dx*dx + dy*dy) rounded to nearest, computed exactly in integers.
// Timing: a measured point occupies the block from its transfer to the next possible one,
// through the squares, the square root unit, which retires one root bit per cycle over
// COORD_BITS + 1 iterations plus a rounding step, and the finish step; the two squares
// share one multiplier on successive cycles. An invalid or ignored point skips straight
// to the finish step. o_stall stays high while a point is being processed. A finished
// result sits in an output register, so a new point is taken while the result waits;
// a second result waits for the first to go.
module nearest_point_search #(
    parameter int MAX_POINTS = npsrch_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = npsrch_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [npsrch_pkg::COORD_W-1:0]  i_origin_x,
    input  logic signed [npsrch_pkg::COORD_W-1:0]  i_origin_y,
    input  logic signed [npsrch_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [npsrch_pkg::COORD_W-1:0]  i_point_y,
    input  logic                                   i_first,
    input  logic                                   i_last,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [npsrch_pkg::IDX_W-1:0]           o_nearest_index
);

    localparam int CWD = npsrch_pkg::COORD_W;
    localparam int IW  = npsrch_pkg::IDX_W;
    // Coordinate differences need one bit more than the coordinates.
    localparam int DW  = COORD_BITS + 1;
    // Root width equals the difference width; the radicand is twice that.
    localparam int RB  = DW;
    localparam int SW  = 2 * RB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_START,
        ST_ROOT,
        ST_FINISH
    } t_state;

    // Sign-extend a coordinate port from bit COORD_BITS-1, dropping higher bits.
    function automatic logic signed [CWD-1:0] sext(input logic [CWD-1:0] raw);
        logic [CWD-1:0] v;
        for (int i = 0; i < CWD; i++) begin
            v[i] = (i < COORD_BITS) ? raw[i] : raw[COORD_BITS-1];
        end
        return $signed(v);
    endfunction

    t_state                 r_state;
    logic signed [CWD-1:0]  r_ox;
    logic signed [CWD-1:0]  r_oy;
    logic [IW-1:0]          r_cnt;
    logic [IW-1:0]          r_best_idx;
    logic                   r_best_valid;
    logic [RB-1:0]          r_best_dist;
    logic signed [DW-1:0]   r_dx;
    logic signed [DW-1:0]   r_dy;
    logic [SW-1:0]          r_sq_x;
    logic [SW-1:0]          r_sq_y;
    logic [RB-1:0]          r_dist;
    logic                   r_take;
    logic                   r_measure;
    logic                   r_last;
    logic                   r_out_valid;
    logic [IW-1:0]          r_out_idx;

    logic signed [CWD-1:0]  n_org_x;
    logic signed [CWD-1:0]  n_org_y;
    logic signed [CWD-1:0]  n_px;
    logic signed [CWD-1:0]  n_py;
    logic signed [CWD:0]    n_dx_full;
    logic signed [CWD:0]    n_dy_full;
    logic [IW-1:0]          n_cnt_base;
    logic                   n_take;
    logic                   n_measure;
    logic                   n_accept;
    logic signed [DW-1:0]   n_mul_op;
    logic signed [SW-1:0]   n_prod;
    logic                   n_upd;
    logic                   n_best_valid;
    logic [IW-1:0]          n_best_idx;
    logic                   n_out_block;
    logic                   n_root_start;
    logic                   n_root_done;
    logic [RB-1:0]          n_root;

    assign n_accept = i_valid && !o_stall;

    // Front end: pick the origin and form both differences at transfer time.
    assign n_org_x    = i_first ? sext(i_origin_x) : r_ox;
    assign n_org_y    = i_first ? sext(i_origin_y) : r_oy;
    assign n_px       = sext(i_point_x);
    assign n_py       = sext(i_point_y);
    assign n_dx_full  = {n_px[CWD-1], n_px} - {n_org_x[CWD-1], n_org_x};
    assign n_dy_full  = {n_py[CWD-1], n_py} - {n_org_y[CWD-1], n_org_y};
    assign n_cnt_base = i_first ? '0 : r_cnt;
    assign n_take     = (n_cnt_base < IW'(MAX_POINTS));
    // A coordinate of -1 (all ones once sign-extended) marks the point invalid.
    assign n_measure  = n_take && (n_px != '1) && (n_py != '1);

    // One multiplier squares dx, then dy, on successive cycles.
    assign n_mul_op = (r_state == ST_SQ_X) ? r_dx : r_dy;
    assign n_prod   = SW'(n_mul_op) * SW'(n_mul_op);

    assign n_root_start = (r_state == ST_START);

    npsrch_sqrt #(
        .ROOT_BITS (RB)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_root_start),
        .i_radicand (r_sq_x + r_sq_y),
        .o_done     (n_root_done),
        .o_root     (n_root)
    );

    // Strictly smaller wins, so ties keep the earlier point.
    assign n_upd        = r_measure && (!r_best_valid || (r_dist < r_best_dist));
    assign n_best_valid = r_best_valid || n_upd;
    assign n_best_idx   = n_upd ? r_cnt : r_best_idx;
    // Hold the closing point while the previous result is still unclaimed.
    assign n_out_block  = r_last && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ox         <= '0;
            r_oy         <= '0;
            r_cnt        <= '0;
            r_best_idx   <= '0;
            r_best_valid <= 1'b0;
            r_best_dist  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_dx      <= n_dx_full[DW-1:0];
                        r_dy      <= n_dy_full[DW-1:0];
                        r_take    <= n_take;
                        r_measure <= n_measure;
                        r_last    <= i_last;
                        r_cnt     <= n_cnt_base;
                        if (i_first) begin
                            r_ox         <= n_org_x;
                            r_oy         <= n_org_y;
                            r_best_idx   <= '0;
                            r_best_valid <= 1'b0;
                            r_best_dist  <= '0;
                        end
                        r_state <= n_measure ? ST_SQ_X : ST_FINISH;
                    end
                end
                ST_SQ_X: begin
                    r_sq_x  <= $unsigned(n_prod);
                    r_state <= ST_SQ_Y;
                end
                ST_SQ_Y: begin
                    r_sq_y  <= $unsigned(n_prod);
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (n_root_done) begin
                        r_dist  <= n_root;
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!n_out_block) begin
                        if (n_upd) begin
                            r_best_valid <= 1'b1;
                            r_best_idx   <= r_cnt;
                            r_best_dist  <= r_dist;
                        end
                        if (r_take) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (r_last) begin
                            // Emit the result and drop the set; the origin stays.
                            r_out_valid  <= 1'b1;
                            r_out_idx    <= n_best_valid ? n_best_idx : '0;
                            r_cnt        <= '0;
                            r_best_valid <= 1'b0;
                            r_best_idx   <= '0;
                            r_best_dist  <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_nearest_index = r_out_idx;

    // A new result only appears out of the finish step.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_FINISH)
        else $error("result appeared outside the finish step");

    // The position counter saturates at MAX_POINTS.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= IW'(MAX_POINTS))
        else $error("point counter passed its limit");

    // A held best always refers to a position already counted.
    a_best_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_valid |-> r_best_idx < r_cnt)
        else $error("best index beyond counted points");

    // An accepted point always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block ready right after a transfer");

    // The root unit only reports while a root is awaited.
    a_root_awaited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_root_done |-> r_state == ST_ROOT)
        else $error("root finished while not awaited");

endmodule

[tb/tb_nearest_point_search.sv]
// Self-checking testbench for the nearest point search block: directed and random point sets.
module tb_nearest_point_search;

    typedef logic signed [npsrch_pkg::COORD_W-1:0] t_coord;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid;
    logic                           o_stall;
    t_coord                         i_origin_x;
    t_coord                         i_origin_y;
    t_coord                         i_point_x;
    t_coord                         i_point_y;
    logic                           i_first;
    logic                           i_last;
    logic                           o_valid;
    logic                           i_stall;
    logic [npsrch_pkg::IDX_W-1:0]   o_nearest_index;

    // Mirror of the block's search state, advanced once per accepted input transfer.
    t_coord               held_ox = '0;
    t_coord               held_oy = '0;
    int unsigned          set_count = 0;
    int unsigned          lead_pos = 0;
    int unsigned          lead_dist = 0;
    bit                   lead_found = 1'b0;

    // Indexes still owed by the block, oldest first.
    logic [npsrch_pkg::IDX_W-1:0] nearest_due[$];

    int unsigned          fault_count = 0;
    int unsigned          points_sent = 0;
    // Set to run both sides without gaps for a stretch.
    bit                   steady_flow = 1'b0;

    nearest_point_search uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_first         (i_first),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_nearest_index (o_nearest_index)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop: far beyond the slowest correct run, including every gap and stall.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fault_count++;
    endtask

    // Round-to-nearest integer square root: floor root bit by bit, then bump it
    // when the sum lies past r*r + r (the halfway point between r and r+1).
    function automatic int unsigned rounded_distance(input longint unsigned sq);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        if (sq > root * root + root)
            root++;
        return int'(root[15:0]);
    endfunction

    // Advance the mirrored search by one point; queue the index owed when the set closes.
    task automatic track_point(input t_coord ox, input t_coord oy, input t_coord px,
                               input t_coord py, input logic opens, input logic closes);
        longint          dx;
        longint          dy;
        longint unsigned sq;
        int unsigned     pt_dist;
        if (opens) begin
            held_ox    = ox;
            held_oy    = oy;
            set_count  = 0;
            lead_found = 1'b0;
            lead_pos   = 0;
            lead_dist  = 0;
        end
        // Positions past the limit are dropped without touching the count.
        if (set_count < npsrch_pkg::MAX_POINTS_DEF) begin
            // An all-ones coordinate is -1: the point holds its position but never leads.
            if (!(&px) && !(&py)) begin
                dx      = longint'(px) - longint'(held_ox);
                dy      = longint'(py) - longint'(held_oy);
                sq      = dx * dx + dy * dy;
                pt_dist = rounded_distance(sq);
                // Strictly smaller only, so a tie keeps the earlier point.
                if (!lead_found || pt_dist < lead_dist) begin
                    lead_found = 1'b1;
                    lead_pos   = set_count;
                    lead_dist  = pt_dist;
                end
            end
            set_count++;
        end
        if (closes) begin
            nearest_due.push_back(lead_found ? lead_pos[npsrch_pkg::IDX_W-1:0] : '0);
            // The held origin survives, so the next point opens a set on its own.
            set_count  = 0;
            lead_found = 1'b0;
            lead_pos   = 0;
            lead_dist  = 0;
        end
    endtask

    // Drive one point after a random gap and hold it until the block takes the transfer.
    // Called and returned at a falling edge; valid stays high across back-to-back points.
    task automatic send_point(input t_coord ox, input t_coord oy, input t_coord px,
                              input t_coord py, input logic opens, input logic closes);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_origin_x <= ox;
        i_origin_y <= oy;
        i_point_x  <= px;
        i_point_y  <= py;
        i_first    <= opens;
        i_last     <= closes;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        track_point(ox, oy, px, py, opens, closes);
        points_sent++;
        @(negedge i_clk);
    endtask

    // Result side: stall for a random number of cycles, then release until one
    // result transfer goes through, and draw again.
    initial begin : result_stall
        int unsigned hold;
        i_stall = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = steady_flow ? 0 : $urandom_range(0, 14);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            @(negedge i_clk);
        end
    end

    // Compare every result transfer with the oldest index owed.
    always @(posedge i_clk) begin : result_check
        logic [npsrch_pkg::IDX_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (nearest_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result, index %0d", o_nearest_index));
            end else begin
                want = nearest_due.pop_front();
                if (o_nearest_index !== want)
                    report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                              o_nearest_index, want));
            end
        end
    end

    // Right after reset the held origin is zero; points without the opening flag use it,
    // and again once a set has closed.
    task automatic test_open_without_first();
        send_point(500, -500, 3, 4, 1'b0, 1'b0);
        send_point(-7, 9, 0, -2, 1'b0, 1'b1);
        send_point(123, 321, 7, 0, 1'b0, 1'b0);
        send_point(-1, -1, -6, 0, 1'b0, 1'b1);
    endtask

    // One-point sets at the corners of the coordinate range: largest possible distances.
    task automatic test_single_point_extremes();
        send_point(-16384, -16384, 16383, 16383, 1'b1, 1'b1);
        send_point(16383, 16383, -16384, -16384, 1'b1, 1'b1);
        send_point(16383, -16384, -16384, 16383, 1'b1, 1'b1);
        send_point(-1, -1, -1, -1, 1'b1, 1'b1);
    endtask

    // A set where nothing is valid reports zero; invalid points still take a position.
    task automatic test_invalid_points();
        send_point(10, 10, -1, 10, 1'b1, 1'b0);
        send_point(0, 0, 10, -1, 1'b0, 1'b0);
        send_point(0, 0, -1, -1, 1'b0, 1'b1);
        send_point(0, 0, -1, 0, 1'b1, 1'b0);
        send_point(0, 0, 5, 5, 1'b0, 1'b0);
        send_point(0, 0, -1, -1, 1'b0, 1'b0);
        send_point(0, 0, 6, 6, 1'b0, 1'b1);
    endtask

    // Distances 3, 2, 1, 1: the tie keeps position 2. Then sums 20 and 18 both sit at or
    // below the halfway point of root 4, so both round to 4 and position 0 stays.
    task automatic test_rounding_and_ties();
        send_point(0, 0, 2, 2, 1'b1, 1'b0);
        send_point(0, 0, 2, 1, 1'b0, 1'b0);
        send_point(0, 0, 1, 1, 1'b0, 1'b0);
        send_point(0, 0, 1, 0, 1'b0, 1'b1);
        send_point(0, 0, 4, 2, 1'b1, 1'b0);
        send_point(0, 0, 3, 3, 1'b0, 1'b1);
    endtask

    // An opening flag partway through a set drops the points before it.
    task automatic test_restart_mid_set();
        send_point(0, 0, 1, 0, 1'b1, 1'b0);
        send_point(100, 100, 90, 100, 1'b1, 1'b0);
        send_point(0, 0, 101, 100, 1'b0, 1'b1);
    endtask

    // Distances shrink toward the last counted position; the points on the origin
    // past the limit must be ignored.
    task automatic test_point_limit();
        for (int i = 0; i < npsrch_pkg::MAX_POINTS_DEF + 5; i++) begin
            if (i < npsrch_pkg::MAX_POINTS_DEF)
                send_point(100, 100, t_coord'(400 - i), 100, i == 0, 1'b0);
            else
                send_point(100, 100, 100, 100, 1'b0, i == npsrch_pkg::MAX_POINTS_DEF + 4);
        end
    endtask

    // Coordinate around a center, anywhere when spread is zero, now and then invalid.
    function automatic t_coord pick_coord(input t_coord centre, input int unsigned spread);
        if ($urandom_range(0, 11) == 0)
            return '1;
        if (spread == 0)
            return t_coord'($urandom);
        return centre + t_coord'($urandom_range(0, 2 * spread) - spread);
    endfunction

    // Mostly well-formed sets with random content; some lack the opening flag and some
    // restart partway. Origins on non-opening points are noise the block must ignore.
    task automatic test_random_sets();
        int unsigned start;
        int unsigned span;
        int unsigned style;
        int unsigned mid;
        int unsigned spread;
        t_coord      ox;
        t_coord      oy;
        logic        opens;
        start = points_sent;
        while (points_sent - start < 420) begin
            if ($urandom_range(0, 15) == 0)
                steady_flow = !steady_flow;
            span  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            style = $urandom_range(0, 9);
            mid   = $urandom_range(0, span - 1);
            case ($urandom_range(0, 2))
                0: spread = 3;
                1: spread = 200;
                default: spread = 0;
            endcase
            ox = t_coord'($urandom);
            oy = t_coord'($urandom);
            for (int i = 0; i < span; i++) begin
                // style 0: no opening flag; style 1: restart at mid; others: well formed
                opens = (i == 0 && style != 0) || (style == 1 && i == mid);
                send_point(opens ? ox : t_coord'($urandom), opens ? oy : t_coord'($urandom),
                           pick_coord(ox, spread), pick_coord(oy, spread),
                           opens, i == span - 1);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_valid    = 1'b0;
        i_origin_x = '0;
        i_origin_y = '0;
        i_point_x  = '0;
        i_point_y  = '0;
        i_first    = 1'b0;
        i_last     = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_open_without_first();
        test_single_point_extremes();
        test_invalid_points();
        test_rounding_and_ties();
        test_restart_mid_set();
        test_point_limit();
        test_random_sets();

        // Drain: wait for every owed result, then a few point times for stray output.
        i_valid <= 1'b0;
        while (nearest_due.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
